/* hw/rtl/rexs_pkg.sv */
package rexs_pkg;

    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;

    // one stored record
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } rec_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] sort_key;
        logic [TAG_BITS-1:0] record_tag;
        logic                last_entry;
    } in_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic [TAG_BITS-1:0] sorted_tag;
        logic                final_record;
        logic                overflow;
    } out_item_t;

endpackage

/* hw/rtl/rexs_store.sv */
module rexs_store #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  rexs_pkg::rec_t             wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output rexs_pkg::rec_t             rd_data
);
    import rexs_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/record_exchange_sort_by_key_core.sv */
// Record sorter: loads records (key, tag) one transfer at a time on the item
// channel until a transfer with last_entry set, sorts them ascending by key
// with an exchange sort, then sends them out on the result channel.
//
// Channels: valid/stall on both sides; a transfer happens when valid is high
// and stall is low. item_stall is low only while loading.
// Capacity: MAX_ENTRIES records; further items are dropped and every result
// of that set carries overflow = 1. final_record marks the last result.
//
// Flow for a set of n records: loading stores each item as it is transferred.
// The sort pass for position i streams positions i+1..n-1 through the single
// read port of the record store, one compare per cycle, with fetch and hold
// before the stream and drain and put after it. Each result then goes through
// read, capture and transfer, and waits while the receiver holds result_stall
// high; a stalled result stays put until taken.
// Reset: empty set, loading, no result pending. The store itself is not
// cleared; only entries written in the current set are ever read.
module record_exchange_sort_by_key_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rexs_pkg::in_item_t   item,
    input  logic                 item_valid,
    output logic                 item_stall,
    output rexs_pkg::out_item_t  result,
    output logic                 result_valid,
    input  logic                 result_stall
);
    import rexs_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [7:0] {
        ST_LOAD     = 8'b0000_0001,
        ST_FETCH    = 8'b0000_0010,  // read record at outer position
        ST_HOLD     = 8'b0000_0100,  // capture it as the held record
        ST_SCAN     = 8'b0000_1000,  // stream later positions, swap on greater
        ST_PUT      = 8'b0001_0000,  // write held record back to outer position
        ST_EMIT_RD  = 8'b0010_0000,
        ST_EMIT_CAP = 8'b0100_0000,
        ST_EMIT_OUT = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [IDX_W-1:0] outer_reg, outer_next;   // also the emit position
    logic [IDX_W-1:0] inner_reg, inner_next;   // next position to read in scan
    logic             issue_done_reg, issue_done_next;
    logic             pend_reg, pend_next;     // read data in flight for scan
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    rec_t             held_reg, held_next;
    out_item_t        result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    // store port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_data;

    logic             item_xfer;
    logic             result_xfer;
    logic             swap;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] last_pos;

    rexs_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item_stall   = (state_reg != ST_LOAD);
    assign item_xfer    = item_valid && !item_stall;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign result_xfer  = result_valid_reg && !result_stall;

    // strict greater keeps equal keys where the exchange order leaves them
    assign swap     = pend_reg && (held_reg.key > rd_data.key);
    assign last_pos = count_reg - CNT_W'(1);
    assign count_inc = (count_reg < CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        outer_next        = outer_reg;
        inner_next        = inner_reg;
        issue_done_next   = issue_done_reg;
        pend_next         = 1'b0;
        pend_idx_next     = inner_reg;
        held_next         = held_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        wr_en             = 1'b0;
        wr_addr           = count_reg[IDX_W-1:0];
        wr_data           = '{key: item.sort_key, tag: item.record_tag};
        rd_addr           = outer_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (item_xfer)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    count_next = count_inc;
                    outer_next = '0;
                    if (item.last_entry)
                    begin
                        state_next = (count_inc >= CNT_W'(2)) ? ST_FETCH : ST_EMIT_RD;
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr    = outer_reg;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                held_next       = rd_data;
                inner_next      = outer_reg + IDX_W'(1);
                issue_done_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr = inner_reg;
                if (!issue_done_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = inner_reg;
                    if (CNT_W'(inner_reg) == last_pos)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        inner_next = inner_reg + IDX_W'(1);
                    end
                end
                if (swap)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = pend_idx_reg;
                    wr_data   = held_reg;
                    held_next = rd_data;
                end
                if (issue_done_reg && !pend_reg)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = outer_reg;
                wr_data = held_reg;
                if (CNT_W'(outer_reg) + CNT_W'(2) < count_reg)
                begin
                    outer_next = outer_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
                else
                begin
                    outer_next = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                rd_addr    = outer_reg;
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP:
            begin
                result_next.sorted_key   = rd_data.key;
                result_next.sorted_tag   = rd_data.tag;
                result_next.final_record = (CNT_W'(outer_reg) == last_pos);
                result_next.overflow     = dropped_reg;
                result_valid_next        = 1'b1;
                state_next               = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (result_xfer)
                begin
                    result_valid_next = 1'b0;
                    if (result_reg.final_record)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        outer_next   = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        outer_next = outer_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            outer_reg        <= '0;
            inner_reg        <= '0;
            issue_done_reg   <= 1'b0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            outer_reg        <= outer_next;
            inner_reg        <= inner_next;
            issue_done_reg   <= issue_done_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        held_reg     <= held_next;
        result_reg   <= result_next;
    end

    // a set is never loaded while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && item_valid && !item_stall))
        else $error("item transfer while result pending");

    // while reads are still issued, scan write-back never hits the entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && swap && !issue_done_reg) |-> (wr_addr != rd_addr))
        else $error("scan read/write collision");

    // store fill never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count beyond capacity");

    // the final transfer empties the set and reopens loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_xfer && result.final_record) |=> (count_reg == '0 && !item_stall))
        else $error("set not cleared after final record");

endmodule
